FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/vsr_pkg.sv
// Types and constants of the video segment reassembler.
`timescale 1ns / 1ps
package vsr_pkg;

    localparam int SEG_BITS   = 7;
    localparam int PREFIX_LEN = 5;

    localparam logic [7:0] LAST_SEG_RESET = 8'hFF;
    localparam logic [3:0] PERIOD_RESET   = 4'd8;
    localparam logic [4:0] NAL_TYPE_SPS   = 5'd7;
    localparam logic [7:0] START_CODE_ONE = 8'h01;

    // Byte position inside a datagram.
    typedef enum logic [1:0] {
        POS_FRAME   = 2'd0,
        POS_SEGMENT = 2'd1,
        POS_PAYLOAD = 2'd2
    } t_pos;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_FORWARD = 2'd1,
        KIND_DROP    = 2'd2,
        KIND_ABANDON = 2'd3
    } t_kind;

    // One result word.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload;
        logic [7:0]  frame_number;
        logic        request_sps;
        logic        run_last;
    } t_result;

    // One queue entry: all results of one input byte (one or two words).
    typedef struct packed {
        t_result first;
        t_result second;
        logic    two;
    } t_entry;

endpackage

FILE: hdl/vsr_front.sv
// Front end: accepts datagram bytes, tracks frame/segment state, builds result entries.
`timescale 1ns / 1ps
module vsr_front
    import vsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte_value,
    input  logic       i_packet_end,
    input  logic       i_queue_full,
    input  logic       i_cfg_wr_en,
    input  logic [3:0] i_cfg_wr_data,
    output logic       o_stall,
    output logic       o_push,
    output t_entry     o_entry
);

    t_pos       r_pos, n_pos;
    logic [7:0] r_header, n_header;
    logic [7:0] r_cur, n_cur;
    logic [7:0] r_last_seg, n_last_seg;
    logic       r_fseen, n_fseen;
    logic       r_disc, n_disc;
    logic       r_sps, n_sps;
    logic [3:0] r_fsr, n_fsr;
    logic [3:0] r_period;
    logic [2:0] r_pcount, n_pcount;
    logic [7:0] r_prefix [PREFIX_LEN];
    logic [7:0] n_prefix [PREFIX_LEN];

    logic       w_accept;
    logic       w_end_of_dgram;

    assign w_accept       = i_valid && !i_queue_full;
    assign o_stall        = i_queue_full;
    assign w_end_of_dgram = (r_pos != POS_FRAME) && i_packet_end;

    // Next byte position.
    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            case (r_pos)
                POS_FRAME: begin
                    n_pos = i_packet_end ? POS_FRAME : POS_SEGMENT;
                end
                default: begin
                    n_pos = i_packet_end ? POS_FRAME : POS_PAYLOAD;
                end
            endcase
        end
    end

    // Datapath and result building.
    always_comb begin
        logic [SEG_BITS-1:0] seg;
        logic                changed;
        logic [7:0]          ls_base;
        logic [7:0]          ls_inc;
        logic                sps_match;
        logic                sps_now;
        logic                have_first;
        logic                have_verdict;
        t_result             first;
        t_result             verdict;

        n_header   = r_header;
        n_cur      = r_cur;
        n_last_seg = r_last_seg;
        n_fseen    = r_fseen;
        n_disc     = r_disc;
        n_sps      = r_sps;
        n_fsr      = r_fsr;
        n_pcount   = r_pcount;
        n_prefix   = r_prefix;
        seg        = i_byte_value[SEG_BITS-1:0];
        changed    = 1'b0;
        ls_base    = r_last_seg;
        ls_inc     = r_last_seg;
        sps_match  = 1'b0;
        sps_now    = r_sps;
        have_first   = 1'b0;
        have_verdict = 1'b0;
        first      = '0;
        verdict    = '0;

        if (w_accept) begin
            case (r_pos)
                POS_FRAME: begin
                    n_header = i_byte_value;
                end
                POS_SEGMENT: begin
                    changed = (r_header != r_cur);
                    n_fseen = i_byte_value[SEG_BITS];
                    if (changed) begin
                        ls_base = {1'b0, seg} - 8'd1;
                        n_cur   = r_header;
                        if (seg != '0) begin
                            n_disc = 1'b1;
                        end
                    end
                    ls_inc = ls_base + 8'd1;
                    if (ls_inc[SEG_BITS-1:0] != seg) begin
                        n_disc = 1'b1;
                    end
                    n_last_seg = {1'b0, seg};
                    if (changed || n_disc) begin
                        if (r_pcount != '0) begin
                            have_first         = 1'b1;
                            first.kind         = KIND_ABANDON;
                            first.frame_number = r_cur;
                        end
                        n_pcount = '0;
                    end
                end
                default: begin
                    if (!r_disc) begin
                        have_first         = 1'b1;
                        first.kind         = KIND_PAYLOAD;
                        first.payload      = i_byte_value;
                        first.frame_number = r_cur;
                        if (r_pcount < 3'(PREFIX_LEN)) begin
                            n_prefix[r_pcount] = i_byte_value;
                            n_pcount           = r_pcount + 3'd1;
                        end
                    end
                end
            endcase

            // Frame end verdict.
            if (w_end_of_dgram && n_fseen) begin
                have_verdict = 1'b1;
                verdict.kind = KIND_DROP;
                sps_match = (n_pcount >= 3'(PREFIX_LEN)) && (n_prefix[0] == 8'h00)
                         && (n_prefix[1] == 8'h00) && (n_prefix[2] == 8'h00)
                         && (n_prefix[3] == START_CODE_ONE)
                         && (n_prefix[4][4:0] == NAL_TYPE_SPS);
                sps_now = r_sps || sps_match;
                if (!n_disc) begin
                    n_sps = sps_now;
                    if (sps_now) begin
                        verdict.kind = KIND_FORWARD;
                    end else if (r_fsr == r_period) begin
                        verdict.request_sps = 1'b1;
                        n_fsr               = 4'd1;
                    end else begin
                        n_fsr = r_fsr + 4'd1;
                    end
                end
                verdict.frame_number = n_cur;
                n_cur      = n_cur + 8'd1;
                n_last_seg = LAST_SEG_RESET;
                n_disc     = 1'b0;
                n_pcount   = '0;
            end
            if (w_end_of_dgram) begin
                n_fseen = 1'b0;
            end
        end

        // Pack; the last word of the byte carries run_last.
        o_push  = w_accept && (have_first || have_verdict);
        o_entry = '0;
        if (have_first) begin
            o_entry.first          = first;
            o_entry.second         = verdict;
            o_entry.two            = have_verdict;
            o_entry.first.run_last = !have_verdict;
            o_entry.second.run_last = 1'b1;
        end else begin
            o_entry.first          = verdict;
            o_entry.first.run_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_FRAME;
            r_header   <= '0;
            r_cur      <= '0;
            r_last_seg <= LAST_SEG_RESET;
            r_fseen    <= 1'b0;
            r_disc     <= 1'b0;
            r_sps      <= 1'b0;
            r_fsr      <= '0;
            r_pcount   <= '0;
            r_period   <= PERIOD_RESET;
        end else begin
            r_pos      <= n_pos;
            r_header   <= n_header;
            r_cur      <= n_cur;
            r_last_seg <= n_last_seg;
            r_fseen    <= n_fseen;
            r_disc     <= n_disc;
            r_sps      <= n_sps;
            r_fsr      <= n_fsr;
            r_pcount   <= n_pcount;
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
        end
    end

    // Prefix bytes: no reset, read only once written.
    always_ff @(posedge i_clk) begin
        r_prefix <= n_prefix;
    end

endmodule

FILE: hdl/vsr_queue.sv
// Result queue between front and back; one entry per input byte that has results.
`timescale 1ns / 1ps
module vsr_queue
    import vsr_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

FILE: hdl/vsr_back.sv
// Back end: unpacks queue entries into single result words behind an output register.
`timescale 1ns / 1ps
module vsr_back
    import vsr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_entry  i_head,
    input  logic    i_stall,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_word
);

    logic    r_valid, n_valid;
    logic    r_half, n_half;
    t_result r_word, n_word;
    logic    w_load;

    assign w_load  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_valid = r_valid;
        n_half  = r_half;
        n_word  = r_word;
        o_pop   = 1'b0;
        if (w_load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_word = r_half ? i_head.second : i_head.first;
                if (i_head.two && !r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    o_pop  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

FILE: hdl/video_segment_reassembler.sv
// Top level of the video segment reassembler: front end, result queue, back end.
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_byte_value, i_packet_end
//  out     | output    | o_out_valid / i_out_stall| o_kind, o_payload, o_frame_number,
//          |           |                          | o_request_sps, o_run_last
//  cfg     | input     | i_cfg_wr_en              | i_cfg_wr_data (sps request period)
//
// Cycles: one input byte per cycle while o_in_stall is low; the front end updates all frame
//   state in the accepting cycle. Each byte yields zero, one or two words; the output register
//   sends one word per cycle while i_out_stall is low, so a two-word byte uses it twice.
// Path: the queue takes a byte's words at the accepting edge and the output register loads
//   them from the queue head, so each word passes the queue and the output register in turn.
// Reset: synchronous, active low; queue empty, period register back to 8.
// Stalls: o_in_stall rises only when the result queue is full; i_out_stall holds the
//   output register while the queue keeps filling behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module video_segment_reassembler
    import vsr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input bytes
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_value,
    input  logic       i_packet_end,
    // results
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_payload,
    output logic [7:0] o_frame_number,
    output logic       o_request_sps,
    output logic       o_run_last,
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic [3:0] i_cfg_wr_data
);

    logic    w_push;
    t_entry  w_entry;
    logic    w_full;
    logic    w_empty;
    t_entry  w_head;
    logic    w_pop;
    t_result w_word;
    logic    w_out_other;    // non-payload word on the out channel
    logic    w_out_request;  // word with a header request on the out channel
    logic    w_out_verdict;  // forward or drop word on the out channel

    // Front end: header parsing, discard tracking, SPS verdicts.
    vsr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_byte_value  (i_byte_value),
        .i_packet_end  (i_packet_end),
        .i_queue_full  (w_full),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_stall       (o_in_stall),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    // Entries of one or two words, in byte order.
    vsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // Back end: one word per cycle to the output register while i_out_stall is low.
    vsr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .i_stall (i_out_stall),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .o_word  (w_word)
    );

    assign o_kind         = w_word.kind;
    assign o_payload      = w_word.payload;
    assign o_frame_number = w_word.frame_number;
    assign o_request_sps  = w_word.request_sps;
    assign o_run_last     = w_word.run_last;

    assign w_out_other   = o_out_valid && (o_kind != KIND_PAYLOAD);
    assign w_out_request = o_out_valid && o_request_sps;
    assign w_out_verdict = o_out_valid && (o_kind inside {KIND_FORWARD, KIND_DROP});

    // The front end never pushes into a full queue.
    `ASSERT_IMPLIES(a_no_push_when_full, i_clk, i_rst_n, w_push, !w_full)
    // Only payload words carry a byte.
    `ASSERT_IMPLIES(a_payload_zero, i_clk, i_rst_n, w_out_other, o_payload == 8'h00)
    // A header request rides only on a drop verdict.
    `ASSERT_IMPLIES(a_request_on_drop, i_clk, i_rst_n, w_out_request, o_kind == KIND_DROP)
    // Verdicts always close the run of a byte.
    `ASSERT_IMPLIES(a_verdict_last, i_clk, i_rst_n, w_out_verdict, o_run_last)

endmodule
